// ===== rtl/jddm_pkg.sv =====
// Shared types and constants for the joystick differential-drive mixer.
package jddm_pkg;

  localparam int AxisW    = 10;
  localparam int MagW     = 11;   // |Y +/- X| reaches 1024
  localparam int SteerW   = 17;   // X * 100
  localparam int ProdW    = 18;   // |m| * 127
  localparam int FullW    = 27;   // |m| * 127 * speed_factor
  localparam int DriveW   = 10;   // full product >> 17
  localparam int DutyW    = 8;
  localparam int DeadW    = 10;
  localparam int SpeedW   = 9;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam int DriveShift = 17;
  localparam int TurboBase  = 255 * 512;
  localparam int TurboGain  = 100;
  localparam int MixGain    = 127;
  localparam int DutyMax    = 255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEAD_ZONE    = 3'd0,
    REG_PWM_MAX      = 3'd1,
    REG_LEFT_TRIM    = 3'd2,
    REG_RIGHT_TRIM   = 3'd3,
    REG_SPEED_FACTOR = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DeadW-1:0]  dead_zone;
    logic [DutyW-1:0]  pwm_max;
    logic [DutyW-1:0]  left_trim;
    logic [DutyW-1:0]  right_trim;
    logic [SpeedW-1:0] speed_factor;
  } cfg_t;

  // Stage 1 result: mixed magnitudes, signs, dead-zone flag, turbo steer term
  typedef struct packed {
    logic                     turbo;
    logic                     centered;
    logic                     l_neg;
    logic                     r_neg;
    logic [MagW-1:0]          l_mag;
    logic [MagW-1:0]          r_mag;
    logic signed [SteerW-1:0] steer;
  } prep_t;

  // Stage 2 result: magnitude times 127, turbo duties
  typedef struct packed {
    logic              turbo;
    logic              centered;
    logic              l_neg;
    logic              r_neg;
    logic [ProdW-1:0]  l_prod;
    logic [ProdW-1:0]  r_prod;
    logic [DutyW-1:0]  l_turbo;
    logic [DutyW-1:0]  r_turbo;
  } scale_t;

  // Stage 3 result: scaled drive magnitudes with final direction
  typedef struct packed {
    logic              turbo;
    logic              centered;
    logic              l_rev;
    logic              r_rev;
    logic [DriveW-1:0] l_drive;
    logic [DriveW-1:0] r_drive;
    logic [DutyW-1:0]  l_turbo;
    logic [DutyW-1:0]  r_turbo;
  } drive_t;

  typedef struct packed {
    logic [DutyW-1:0] left_forward;
    logic [DutyW-1:0] left_reverse;
    logic [DutyW-1:0] right_forward;
    logic [DutyW-1:0] right_reverse;
  } duty_t;

  function automatic logic [DutyW-1:0] sat_add(input logic [DutyW-1:0] a,
                                               input logic [DutyW-1:0] b);
    logic [DutyW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DutyW] ? DutyW'(DutyMax) : sum[DutyW-1:0];
  endfunction

endpackage

// ===== rtl/jddm_prep.sv =====
// Stage 1: axis decode, arcade mix sums, dead-zone test, turbo steer term.
module jddm_prep import jddm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AxisW-1:0]  axis_x,
  input  logic [AxisW-1:0]  axis_y,
  input  logic              turbo,
  input  logic [DeadW-1:0]  dead_zone,
  output logic              out_valid,
  input  logic              out_ready,
  output prep_t             out_data
);

  logic signed [MagW:0]      x_ext;
  logic signed [MagW:0]      y_fwd;
  logic signed [MagW:0]      mix_l;
  logic signed [MagW:0]      mix_r;
  logic signed [MagW:0]      neg_l;
  logic signed [MagW:0]      neg_r;
  logic signed [MagW:0]      abs_x;
  logic signed [MagW:0]      abs_y;
  logic signed [SteerW-1:0]  steer;
  prep_t                     prep;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    x_ext = $signed({{(MagW+1-AxisW){axis_x[AxisW-1]}}, axis_x});
    // raw vertical is down-positive; flip so up is forward
    y_fwd = -$signed({{(MagW+1-AxisW){axis_y[AxisW-1]}}, axis_y});
    mix_l = y_fwd + x_ext;
    mix_r = y_fwd - x_ext;
    neg_l = -mix_l;
    neg_r = -mix_r;
    abs_x = x_ext[MagW] ? -x_ext : x_ext;
    abs_y = y_fwd[MagW] ? -y_fwd : y_fwd;
    steer = $signed({{(SteerW-AxisW){axis_x[AxisW-1]}}, axis_x}) * SteerW'(TurboGain);

    prep.turbo    = turbo;
    prep.centered = (abs_x[DeadW-1:0] < dead_zone) && (abs_y[DeadW-1:0] < dead_zone);
    prep.l_neg    = mix_l[MagW];
    prep.r_neg    = mix_r[MagW];
    prep.l_mag    = mix_l[MagW] ? neg_l[MagW-1:0] : mix_l[MagW-1:0];
    prep.r_mag    = mix_r[MagW] ? neg_r[MagW-1:0] : mix_r[MagW-1:0];
    prep.steer    = steer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= prep;
    end
  end

endmodule

// ===== rtl/jddm_scale.sv =====
// Stages 2 and 3: gain of 127 and turbo duties, then speed-factor scaling.
module jddm_scale import jddm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  prep_t             in_data,
  input  logic [SpeedW-1:0] speed_factor,
  output logic              out_valid,
  input  logic              out_ready,
  output drive_t            out_data
);

  logic              mid_valid;
  logic              mid_ready;
  scale_t            mid_data;
  scale_t            scale;
  drive_t            drive;
  logic [FullW-1:0]  l_full;
  logic [FullW-1:0]  r_full;

  // floor(255 + g/512), limited to 255; the sum is always positive
  function automatic logic [DutyW-1:0] turbo_duty(input logic signed [SteerW:0] g);
    logic signed [SteerW+1:0] n;
    n = $signed((SteerW+2)'(TurboBase)) + $signed({g[SteerW], g});
    return (n[SteerW+1:9] > (SteerW-7)'(DutyMax)) ? DutyW'(DutyMax) : n[9+DutyW-1:9];
  endfunction

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  always_comb begin
    scale.turbo    = in_data.turbo;
    scale.centered = in_data.centered;
    scale.l_neg    = in_data.l_neg;
    scale.r_neg    = in_data.r_neg;
    scale.l_prod   = ProdW'(in_data.l_mag) * ProdW'(MixGain);
    scale.r_prod   = ProdW'(in_data.r_mag) * ProdW'(MixGain);
    scale.l_turbo  = turbo_duty({in_data.steer[SteerW-1], in_data.steer});
    scale.r_turbo  = turbo_duty(-{in_data.steer[SteerW-1], in_data.steer});
  end

  always_comb begin
    l_full = FullW'(mid_data.l_prod) * FullW'(speed_factor);
    r_full = FullW'(mid_data.r_prod) * FullW'(speed_factor);
    drive.turbo    = mid_data.turbo;
    drive.centered = mid_data.centered;
    // a zero speed factor gives a zero product, which counts as forward
    drive.l_rev    = mid_data.l_neg && (speed_factor != '0);
    drive.r_rev    = mid_data.r_neg && (speed_factor != '0);
    drive.l_drive  = l_full[DriveShift +: DriveW];
    drive.r_drive  = r_full[DriveShift +: DriveW];
    drive.l_turbo  = mid_data.l_turbo;
    drive.r_turbo  = mid_data.r_turbo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mid_data <= scale;
    end
    if (mid_valid && mid_ready) begin
      out_data <= drive;
    end
  end

endmodule

// ===== rtl/jddm_drive.sv =====
// Stage 4: pwm_max limit, trim, saturation and channel steering; output register.
module jddm_drive import jddm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  drive_t           in_data,
  input  logic [DutyW-1:0] pwm_max,
  input  logic [DutyW-1:0] left_trim,
  input  logic [DutyW-1:0] right_trim,
  output logic             out_valid,
  input  logic             out_ready,
  output duty_t            out_data
);

  logic [DutyW-1:0] l_lim;
  logic [DutyW-1:0] r_lim;
  logic [DutyW-1:0] l_duty;
  logic [DutyW-1:0] r_duty;
  duty_t            duty;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    l_lim  = (in_data.l_drive > DriveW'(pwm_max)) ? pwm_max : in_data.l_drive[DutyW-1:0];
    r_lim  = (in_data.r_drive > DriveW'(pwm_max)) ? pwm_max : in_data.r_drive[DutyW-1:0];
    l_duty = sat_add(l_lim, left_trim);
    r_duty = sat_add(r_lim, right_trim);
    duty   = '0;
    if (in_data.turbo) begin
      duty.left_forward  = sat_add(in_data.l_turbo, left_trim);
      duty.right_forward = sat_add(in_data.r_turbo, right_trim);
    end else if (!in_data.centered) begin
      if (in_data.l_rev) begin
        duty.left_reverse = l_duty;
      end else begin
        duty.left_forward = l_duty;
      end
      if (in_data.r_rev) begin
        duty.right_reverse = r_duty;
      end else begin
        duty.right_forward = r_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= duty;
    end
  end

endmodule

// ===== rtl/joystick_differential_drive_mixer_core.sv =====
// Top level of the joystick differential-drive mixer: config registers and pipeline.
//
// One joystick sample in, four H-bridge duty values out. The mixer is a
// four-stage pipeline (decode and mix, gain of 127, speed-factor multiply,
// limit/trim/steer) with an output register, so it takes one sample every
// clock unless the output stalls; each result passes each stage register in turn.
// Every stage has its own valid bit and holds under back-pressure, so bubbles
// are squeezed out and a stalled output still lets upstream stages fill.
// Configuration writes are always accepted (cfg_ready is tied high); write
// them only while no sample is in flight. Indexes beyond speed_factor are
// ignored.
module joystick_differential_drive_mixer_core import jddm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // axis_x[9:0], axis_y[19:10], zero pad
  input  logic                s_axis_tuser,  // turbo
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // left_forward[7:0], left_reverse[15:8], right_forward[23:16], right_reverse[31:24]
  output logic [31:0]         m_axis_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t   cfg;
  logic   prep_valid;
  logic   prep_ready;
  prep_t  prep_data;
  logic   drv_valid;
  logic   drv_ready;
  drive_t drv_data;
  duty_t  duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone    <= DeadW'(20);
      cfg.pwm_max      <= DutyW'(220);
      cfg.left_trim    <= '0;
      cfg.right_trim   <= '0;
      cfg.speed_factor <= SpeedW'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEAD_ZONE:    cfg.dead_zone    <= cfg_data[DeadW-1:0];
        REG_PWM_MAX:      cfg.pwm_max      <= cfg_data[DutyW-1:0];
        REG_LEFT_TRIM:    cfg.left_trim    <= cfg_data[DutyW-1:0];
        REG_RIGHT_TRIM:   cfg.right_trim   <= cfg_data[DutyW-1:0];
        REG_SPEED_FACTOR: cfg.speed_factor <= cfg_data[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  jddm_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .axis_x    (s_axis_tdata[AxisW-1:0]),
    .axis_y    (s_axis_tdata[2*AxisW-1:AxisW]),
    .turbo     (s_axis_tuser),
    .dead_zone (cfg.dead_zone),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  jddm_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (prep_valid),
    .in_ready     (prep_ready),
    .in_data      (prep_data),
    .speed_factor (cfg.speed_factor),
    .out_valid    (drv_valid),
    .out_ready    (drv_ready),
    .out_data     (drv_data)
  );

  jddm_drive u_drive (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (drv_valid),
    .in_ready   (drv_ready),
    .in_data    (drv_data),
    .pwm_max    (cfg.pwm_max),
    .left_trim  (cfg.left_trim),
    .right_trim (cfg.right_trim),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (duty)
  );

  assign m_axis_tdata = {duty.right_reverse, duty.right_forward,
                         duty.left_reverse, duty.left_forward};

  // a side never drives both bridge channels at once
  a_left_one_dir: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (duty.left_forward == '0 || duty.left_reverse == '0))
    else $error("left motor drives both directions");

  a_right_one_dir: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (duty.right_forward == '0 || duty.right_reverse == '0))
    else $error("right motor drives both directions");

  // with the output register empty, every stage must be able to advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // an input into an empty pipeline reaches the output whatever the sink does
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !prep_valid && !u_scale.mid_valid && !drv_valid
     && !m_axis_tvalid) |-> ##4 m_axis_tvalid)
    else $error("transaction lost in pipeline");

endmodule

// ===== test/mixer_duty_checker.sv =====
// Checker for the joystick mixer: shadows the registers, predicts each duty set and compares.
module mixer_duty_checker import jddm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [31:0]         m_axis_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  checked,
  output int                  outstanding
);

  localparam int DeadZoneInit = 20;
  localparam int PwmMaxInit   = 220;
  localparam int SpeedUnity   = 256;

  // lowest byte first on the bus, so the last member is left_forward
  typedef struct packed {
    logic [DutyW-1:0] right_reverse;
    logic [DutyW-1:0] right_forward;
    logic [DutyW-1:0] left_reverse;
    logic [DutyW-1:0] left_forward;
  } bridge_duty_t;

  cfg_t         shadow;
  bridge_duty_t duty_q[$];
  int           errors   = 0;
  int           compared = 0;

  function automatic int clip_duty(int v);
    return v > DutyMax ? DutyMax : v;
  endfunction

  // turbo numerator is always positive, so the divide is a plain floor
  function automatic int turbo_duty(int steer);
    return clip_duty((TurboBase + steer) / 512);
  endfunction

  function automatic void mix_side(input int m, input int trim, output int fwd, output int rev);
    longint prod;
    longint mag;
    int     sf;
    int     duty;
    sf   = int'(shadow.speed_factor);
    prod = longint'(m) * MixGain * sf;
    mag  = (prod < 0 ? -prod : prod) >> DriveShift;
    if (mag > longint'(shadow.pwm_max)) mag = longint'(shadow.pwm_max);
    duty = clip_duty(int'(mag) + trim);
    // a zero product goes forward; any negative product goes reverse
    if (prod >= 0) begin
      fwd = duty;
      rev = 0;
    end else begin
      fwd = 0;
      rev = duty;
    end
  endfunction

  function automatic bridge_duty_t predict_duties(int x, int raw_y, logic turbo);
    bridge_duty_t d;
    int           y;
    int           dz;
    int           steer;
    int           lf, lr, rf, rr;
    d     = '0;
    y     = -raw_y;
    dz    = int'(shadow.dead_zone);
    steer = x * TurboGain;
    if (turbo) begin
      d.left_forward  = DutyW'(clip_duty(turbo_duty(steer) + int'(shadow.left_trim)));
      d.right_forward = DutyW'(clip_duty(turbo_duty(-steer) + int'(shadow.right_trim)));
    end else if (!((x < 0 ? -x : x) < dz && (y < 0 ? -y : y) < dz)) begin
      mix_side(y + x, int'(shadow.left_trim), lf, lr);
      mix_side(y - x, int'(shadow.right_trim), rf, rr);
      d.left_forward  = DutyW'(lf);
      d.left_reverse  = DutyW'(lr);
      d.right_forward = DutyW'(rf);
      d.right_reverse = DutyW'(rr);
    end
    return d;
  endfunction

  function automatic int field_mismatch(string name, logic [DutyW-1:0] want,
                                        logic [DutyW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    bridge_duty_t want;
    bridge_duty_t got;
    int           bad;
    if (rst) begin
      shadow.dead_zone    = DeadW'(DeadZoneInit);
      shadow.pwm_max      = DutyW'(PwmMaxInit);
      shadow.left_trim    = '0;
      shadow.right_trim   = '0;
      shadow.speed_factor = SpeedW'(SpeedUnity);
      duty_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEAD_ZONE:    shadow.dead_zone    = cfg_data[DeadW-1:0];
          REG_PWM_MAX:      shadow.pwm_max      = cfg_data[DutyW-1:0];
          REG_LEFT_TRIM:    shadow.left_trim    = cfg_data[DutyW-1:0];
          REG_RIGHT_TRIM:   shadow.right_trim   = cfg_data[DutyW-1:0];
          REG_SPEED_FACTOR: shadow.speed_factor = cfg_data[SpeedW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        duty_q.push_back(predict_duties(int'($signed(s_axis_tdata[AxisW-1:0])),
                                        int'($signed(s_axis_tdata[2*AxisW-1:AxisW])),
                                        s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (duty_q.size() == 0) begin
          $error("duty transaction with no sample pending: %h", m_axis_tdata);
          errors++;
        end else begin
          got  = m_axis_tdata;
          want = duty_q.pop_front();
          bad  = field_mismatch("left_forward", want.left_forward, got.left_forward)
               + field_mismatch("left_reverse", want.left_reverse, got.left_reverse)
               + field_mismatch("right_forward", want.right_forward, got.right_forward)
               + field_mismatch("right_reverse", want.right_reverse, got.right_reverse);
          errors += bad;
          compared++;
        end
      end
    end
    fail_count  <= errors;
    checked     <= compared;
    outstanding <= duty_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the mixer testbench: clock, reset, register settings, joystick stimulus and verdict.
module testbench import jddm_pkg::*;;

  localparam logic [CfgIdxW-1:0] RegBeyond = CfgIdxW'(REG_SPEED_FACTOR) + 1'b1;
  localparam int PhaseSamples = 155;
  localparam int RandomPhases = 10;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic [23:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [31:0]         m_axis_tdata;
  logic                cfg_ready;

  int mismatches;
  int results_checked;
  int in_flight;
  int stall_left   = 0;
  int samples_sent = 0;
  int turbo_sent   = 0;
  int settings_run = 0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;

  joystick_differential_drive_mixer_core dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mixer_duty_checker duty_check (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count(mismatches), .checked(results_checked), .outstanding(in_flight)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_axis();
    case ($urandom_range(0, 9))
      6, 7:    return int'($urandom_range(0, 80)) - 40;
      8, 9:    return $urandom_range(0, 1) ? -512 : 511;
      default: return int'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 99) < 30) stall_left = gap_len();
    end
  end

  task automatic send_sample(input int x, input int y, input logic turbo);
    int idle;
    idle = (!src_steady && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(24 - 2*AxisW){1'b0}}, AxisW'(y), AxisW'(x)};
    s_axis_tuser  <= turbo;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
    if (turbo) turbo_sent++;
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain the pipeline so registers change only while the mixer is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input int dz, input int pwm, input int lt, input int rt,
                                input int sf);
    drain();
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_PWM_MAX, pwm);
    write_reg(REG_LEFT_TRIM, lt);
    write_reg(REG_RIGHT_TRIM, rt);
    write_reg(REG_SPEED_FACTOR, sf);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int dz, lt, rt;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    settings_run = 1;

    // reset settings: centered, turbo, full-scale and sign corner cases
    send_sample(0, 0, 1'b0);
    send_sample(0, 0, 1'b1);
    send_sample(511, 0, 1'b1);
    send_sample(-512, -512, 1'b1);
    send_sample(0, -512, 1'b0);
    send_sample(0, 511, 1'b0);
    send_sample(-512, -512, 1'b0);
    send_sample(511, 511, 1'b0);
    send_sample(511, -512, 1'b0);
    send_sample(-512, 511, 1'b0);
    send_sample(19, -19, 1'b0);
    send_sample(20, 0, 1'b0);
    send_sample(0, -20, 1'b0);
    send_sample(-25, -23, 1'b0);   // left drive is a sliver below zero
    send_sample(-25, 25, 1'b0);    // right mix exactly zero, left drive in reverse

    apply_settings(0, 255, 255, 255, 511);
    send_sample(0, 0, 1'b0);
    send_sample(511, -512, 1'b1);
    send_sample(-1, 1, 1'b0);
    send_sample(-512, -512, 1'b0);

    apply_settings(1023, 0, 0, 0, 0);
    send_sample(-512, 511, 1'b0);
    send_sample(100, -300, 1'b1);

    // writes past the last register must leave the settings alone
    drain();
    write_reg(RegBeyond, $urandom_range(0, 1023));
    write_reg(CfgIdxW'($urandom_range(RegBeyond, (1 << CfgIdxW) - 1)),
              $urandom_range(0, 1023));
    cfg_valid <= 1'b0;
    send_sample(300, -200, 1'b0);
    send_sample(-7, 0, 1'b0);

    apply_settings(512, 255, 0, 0, 511);
    send_sample(-511, 0, 1'b0);
    send_sample(0, -512, 1'b0);

    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 5))
        0:       dz = 0;
        1:       dz = $urandom_range(513, 1023);
        default: dz = $urandom_range(1, 64);
      endcase
      lt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      rt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      apply_settings(dz, $urandom_range(0, 255), lt, rt, $urandom_range(0, 511));
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady <= ($urandom_range(0, 3) == 0);
      repeat (PhaseSamples) send_sample(pick_axis(), pick_axis(), $urandom_range(0, 3) == 0);
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (10) @(posedge clk);
    $display("Drove %0d joystick samples (%0d in turbo) across %0d register settings;",
             samples_sent, turbo_sent, settings_run);
    $display("%0d duty transactions compared field by field.", results_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
